### hdl/lrca_pkg.sv
// Shared constants, payload types and control types for the lazy row-cleared accumulators.
package lrca_pkg;

    // Store geometry
    localparam int DOC_COUNT   = 65536;
    localparam int ROW_BITS    = 10;
    localparam int ROW_W       = 1 << ROW_BITS;
    localparam int ROW_TOTAL   = (DOC_COUNT + ROW_W - 1) >> ROW_BITS;
    localparam int STORE_DEPTH = ROW_TOTAL * ROW_W;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_IDX_W   = (ROW_TOTAL > 1) ? $clog2(ROW_TOTAL) : 1;
    localparam int COL_W       = (ROW_BITS > 0) ? ROW_BITS : 1;

    // Field widths
    localparam int OP_W    = 2;
    localparam int DOC_W   = 16;
    localparam int COUNT_W = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_TOUCH = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Input item
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [DOC_W-1:0] doc_id;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [COUNT_W-1:0] doc_count;
        logic               row_live;
    } out_item_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TOUCH_WR,
        ST_CLEAR,
        ST_READ_OUT
    } state_t;

    // Counter memory access
    typedef struct packed {
        logic               we;
        logic               re;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] wdata;
    } ram_req_t;

    // Result handoff to the output register
    typedef struct packed {
        logic load;
        logic live;
    } result_t;

endpackage

### hdl/lrca_score_ram.sv
// Counter memory: one write or read port, registered read data.
module lrca_score_ram (
    input  logic                            clk,
    input  lrca_pkg::ram_req_t              req,
    output logic [lrca_pkg::COUNT_W-1:0]    rdata
);

    logic [lrca_pkg::COUNT_W-1:0] mem [lrca_pkg::STORE_DEPTH];
    logic [lrca_pkg::COUNT_W-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lrca_ctrl.sv
// Controller: row flags, row clear sweep and read-modify-write sequencing.
module lrca_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lrca_pkg::in_item_t            in_data,
    input  logic [lrca_pkg::COUNT_W-1:0]  rdata,
    input  logic                          slot_free,
    output lrca_pkg::ram_req_t            ram_req,
    output lrca_pkg::result_t             res
);

    localparam logic [lrca_pkg::COL_W-1:0]  LAST_COL = lrca_pkg::COL_W'(lrca_pkg::ROW_W - 1);
    localparam logic [lrca_pkg::ADDR_W-1:0] COL_MASK = lrca_pkg::ADDR_W'(lrca_pkg::ROW_W - 1);

    lrca_pkg::state_t                  state_reg, state_next;
    logic [lrca_pkg::ROW_TOTAL-1:0]    flags_reg, flags_next;
    logic [lrca_pkg::ROW_IDX_W-1:0]    row_reg, row_next;
    logic [lrca_pkg::COL_W-1:0]        col_reg, col_next;
    logic [lrca_pkg::COL_W-1:0]        hit_col_reg, hit_col_next;
    logic [lrca_pkg::ADDR_W-1:0]       addr_reg, addr_next;
    logic                              live_reg, live_next;

    logic [lrca_pkg::ADDR_W-1:0]       in_addr;
    logic [lrca_pkg::ROW_IDX_W-1:0]    in_row;
    logic                              in_range;
    logic                              in_flag;

    // Decode the incoming document
    always_comb
    begin
        in_addr  = lrca_pkg::ADDR_W'(in_data.doc_id);
        in_row   = lrca_pkg::ROW_IDX_W'(in_addr >> lrca_pkg::ROW_BITS);
        in_range = (32'(in_data.doc_id) < 32'(lrca_pkg::DOC_COUNT));
        in_flag  = in_range && flags_reg[in_row];
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrca_pkg::ST_IDLE;
            flags_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            flags_reg <= flags_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        hit_col_reg <= hit_col_next;
        addr_reg    <= addr_next;
        live_reg    <= live_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next   = state_reg;
        flags_next   = flags_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        hit_col_next = hit_col_reg;
        addr_next    = addr_reg;
        live_next    = live_reg;
        ram_req      = '0;
        res          = '0;
        in_ready     = (state_reg == lrca_pkg::ST_IDLE);

        unique case (state_reg)
            lrca_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.op)
                        lrca_pkg::OP_START:
                        begin
                            flags_next = '0;
                        end
                        lrca_pkg::OP_TOUCH:
                        begin
                            if (in_range)
                            begin
                                if (in_flag)
                                begin
                                    // Row live: fetch counter, increment next cycle
                                    ram_req.re = 1'b1;
                                    ram_req.addr = in_addr;
                                    addr_next = in_addr;
                                    state_next = lrca_pkg::ST_TOUCH_WR;
                                end
                                else
                                begin
                                    // First touch of the row: sweep it
                                    row_next = in_row;
                                    col_next = '0;
                                    hit_col_next = lrca_pkg::COL_W'(in_addr & COL_MASK);
                                    state_next = lrca_pkg::ST_CLEAR;
                                end
                            end
                        end
                        lrca_pkg::OP_READ:
                        begin
                            live_next = in_flag;
                            ram_req.re = in_flag;
                            ram_req.addr = in_addr;
                            state_next = lrca_pkg::ST_READ_OUT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            lrca_pkg::ST_TOUCH_WR:
            begin
                ram_req.we = 1'b1;
                ram_req.addr = addr_reg;
                ram_req.wdata = lrca_pkg::COUNT_W'(rdata + 1'b1);
                state_next = lrca_pkg::ST_IDLE;
            end

            lrca_pkg::ST_CLEAR:
            begin
                // Zero the row; the touched counter starts at one
                ram_req.we = 1'b1;
                ram_req.addr = (lrca_pkg::ADDR_W'(row_reg) << lrca_pkg::ROW_BITS)
                             | (lrca_pkg::ADDR_W'(col_reg) & COL_MASK);
                ram_req.wdata = (col_reg == hit_col_reg) ? lrca_pkg::COUNT_W'(1) : '0;
                if (col_reg == LAST_COL)
                begin
                    flags_next[row_reg] = 1'b1;
                    state_next = lrca_pkg::ST_IDLE;
                end
                else
                begin
                    col_next = lrca_pkg::COL_W'(col_reg + 1'b1);
                end
            end

            lrca_pkg::ST_READ_OUT:
            begin
                // Hand the result over once the output register can take it
                if (slot_free)
                begin
                    res.load = 1'b1;
                    res.live = live_reg;
                    state_next = lrca_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lrca_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/lazy_row_cleared_accumulators.sv
// Top level: lazy row-cleared score accumulators with output register.
//
// Input channel (in_valid/in_ready/in_data) takes one item per transfer:
// op start clears every row flag, op touch increments a document counter,
// op read returns the counter (0 with row_live low if the row is not live).
// Only reads give a result, on out_valid/out_ready/out_data.
// A start or an ignored op leaves the controller idle. A touch of a live row is
// a read-modify-write of the counter memory. The first touch of a row in a
// query sweeps the row, one counter write per cycle, before the controller
// returns to idle. A read passes through the registered read data of the
// memory and the ST_READ_OUT state before out_valid is set.
// The output register holds one result; while it waits, the block keeps
// taking touches and starts, and a further read waits in the controller
// until the register is taken.
// Reset clears the row flags and the control state; the counter memory is
// not cleared, since a row is swept before any of its counters is read.
module lazy_row_cleared_accumulators (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lrca_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lrca_pkg::out_item_t   out_data
);

    lrca_pkg::ram_req_t              ram_req;
    lrca_pkg::result_t               res;
    logic [lrca_pkg::COUNT_W-1:0]    rdata;
    logic                            slot_free;
    logic                            out_valid_reg;
    lrca_pkg::out_item_t             out_data_reg;

    assign slot_free = !out_valid_reg || out_ready;

    lrca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .rdata     (rdata),
        .slot_free (slot_free),
        .ram_req   (ram_req),
        .res       (res)
    );

    lrca_score_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload; a dead row reads as zero
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            out_data_reg.doc_count <= res.live ? rdata : '0;
            out_data_reg.row_live  <= res.live;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
